### src/merge_sort_engine_top_defines.svh
// Assertion macros for the merge sort engine core (mse_core).
// Depends on nothing; the assertions vanish when SYNTHESIS is defined.
`ifndef MERGE_SORT_ENGINE_TOP_DEFINES_SVH
`define MERGE_SORT_ENGINE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define MSE_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error("mse");
`define MSE_NEVER(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error("mse");
`else
`define MSE_ASSERT(label, prop)
`define MSE_NEVER(label, cond)
`endif
`endif

### src/mse_pkg.sv
// Shared types for the merge sort engine.
// Used by the front end, the item queue and the sort core.
package mse_pkg;
  typedef struct packed {
    logic [31:0] value;
    logic        last;
  } item_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_INIT,
    ST_MERGE,
    ST_EMIT
  } sort_state_e;
endpackage

### src/merge_sort_engine_top.sv
// Merge sort engine: items pass through a two-entry queue into the sort core,
// which takes one item per cycle while the queue is not empty as it loads a set of
// signed values. When the last item of a set arrives, the N stored values are
// sorted in ascending order in ceil(log2 N) passes over a two-bank buffer with
// one comparison per cycle; an INIT state comes before each pass and before the
// emit. Each result is held on the outputs until pop takes it, and new items wait
// in the queue until the whole set has been emitted.
// Items past MaxItems are dropped and flag overflow on every result of the set.
module merge_sort_engine_top #(
  parameter int MaxItems = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [31:0] value_in_i,
  input  logic        last_in_i,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] value_out_o,
  output logic        last_out_o,
  output logic        overflow_o
);
  mse_pkg::item_t q_item;
  logic q_empty, q_take;

  mse_front u_front (
    .clk_i (clk_i), .rst_ni (rst_ni), .push_i (push), .value_in_i (value_in_i),
    .last_in_i (last_in_i), .full_o (full), .pop_i (q_take), .item_o (q_item),
    .empty_o (q_empty)
  );

  mse_core #(.MaxItems(MaxItems)) u_core (
    .clk_i (clk_i), .rst_ni (rst_ni), .item_i (q_item), .item_valid_i (!q_empty),
    .item_take_o (q_take), .value_out_o (value_out_o), .last_out_o (last_out_o),
    .overflow_o (overflow_o), .empty_o (empty), .pop_i (pop)
  );
endmodule

### src/mse_queue.sv
// Small item queue between the front end and the sort core.
// Uses mse_pkg::item_t.
module mse_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mse_pkg::item_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output mse_pkg::item_t data_o,
  output logic           empty_o
);
  mse_pkg::item_t mem_q [2];
  logic [1:0] wp_q, rp_q;

  assign full_o  = (wp_q[0] == rp_q[0]) && (wp_q[1] != rp_q[1]);
  assign empty_o = (wp_q == rp_q);
  assign data_o  = mem_q[rp_q[0]];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      mem_q[wp_q[0]] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
    end else begin
      if (push_i && !full_o) wp_q <= wp_q + 2'd1;
      if (pop_i && !empty_o) rp_q <= rp_q + 2'd1;
    end
  end
endmodule

### src/mse_front.sv
// Front end: takes items from the input port and passes them to the queue.
// Uses mse_pkg and mse_queue.
module mse_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  logic [31:0]    value_in_i,
  input  logic           last_in_i,
  output logic           full_o,
  input  logic           pop_i,
  output mse_pkg::item_t item_o,
  output logic           empty_o
);
  mse_pkg::item_t in_item;

  assign in_item.value = value_in_i;
  assign in_item.last  = last_in_i;

  mse_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .data_i  (in_item),
    .full_o  (full_o),
    .pop_i   (pop_i),
    .data_o  (item_o),
    .empty_o (empty_o)
  );
endmodule

### src/mse_core.sv
// Sort core: stores a set, sorts it by bottom-up merge passes and emits it.
// Uses mse_pkg and the assertion macros.
`include "merge_sort_engine_top_defines.svh"
module mse_core #(
  parameter int MaxItems = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mse_pkg::item_t item_i,
  input  logic           item_valid_i,
  output logic           item_take_o,
  output logic [31:0]    value_out_o,
  output logic           last_out_o,
  output logic           overflow_o,
  output logic           empty_o,
  input  logic           pop_i
);
  localparam int AW = (MaxItems > 1) ? $clog2(MaxItems) : 1;
  localparam int CW = $clog2(MaxItems + 1);
  localparam int WW = AW + 1;

  logic [31:0] mem_q [2][MaxItems];
  mse_pkg::sort_state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          ovf_q, ovf_d;
  logic          bank_q, bank_d;
  logic [WW-1:0] width_q, width_d;
  logic [WW:0]   lo_q, lo_d, i_q, i_d, j_q, j_d, k_q, k_d;
  logic [WW:0]   mid, hi;
  logic [31:0]   a_rd, b_rd;
  logic [31:0]   ha_q, hb_q;
  logic [AW-1:0] rd_a;
  logic          out_v_q, out_v_d;
  logic [31:0]   out_val_q;
  logic          out_last_q, out_ovf_q;
  logic          take_i, pick_a, do_wr, emit_ld;
  logic [31:0]   wr_val;

  // The heads of both runs are registered from the buffer in the cycle before they are used.
  assign mid = ((lo_q + (WW+1)'(width_q)) > (WW+1)'(cnt_q)) ? (WW+1)'(cnt_q)
             : lo_q + (WW+1)'(width_q);
  assign hi  = ((lo_q + {width_q, 1'b0}) > (WW+1)'(cnt_q)) ? (WW+1)'(cnt_q)
             : lo_q + {width_q, 1'b0};
  assign a_rd = ha_q;
  assign b_rd = hb_q;
  assign pick_a = (i_q < mid) &&
                  ((j_q >= hi) || ($signed(a_rd) <= $signed(b_rd)));
  assign wr_val = pick_a ? a_rd : b_rd;
  assign do_wr  = (state_q == mse_pkg::ST_MERGE) && (k_q < hi);
  assign take_i = (state_q == mse_pkg::ST_LOAD) && item_valid_i;
  assign item_take_o = take_i;
  assign emit_ld = (state_q == mse_pkg::ST_EMIT) && !(out_v_q && !pop_i);
  assign rd_a = (state_q == mse_pkg::ST_EMIT) ? k_q[AW-1:0] : i_d[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (take_i && (CW'(MaxItems) > cnt_q)) begin
      mem_q[0][cnt_q[AW-1:0]] <= item_i.value;
    end
    if (do_wr) begin
      mem_q[~bank_q][k_q[AW-1:0]] <= wr_val;
    end
    if ((state_q == mse_pkg::ST_INIT) || (state_q == mse_pkg::ST_MERGE)) begin
      ha_q <= mem_q[bank_q][rd_a];
      hb_q <= mem_q[bank_q][j_d[AW-1:0]];
    end
    if (emit_ld) begin
      out_val_q  <= mem_q[bank_q][rd_a];
      out_last_q <= (k_q + (WW+1)'(1)) == (WW+1)'(cnt_q);
      out_ovf_q  <= ovf_q;
    end
  end

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; ovf_d = ovf_q; bank_d = bank_q;
    width_d = width_q; lo_d = lo_q; i_d = i_q; j_d = j_q; k_d = k_q;
    out_v_d = out_v_q && !pop_i;
    unique case (state_q)
      mse_pkg::ST_LOAD: begin
        if (take_i) begin
          if (cnt_q < CW'(MaxItems)) cnt_d = cnt_q + CW'(1);
          else ovf_d = 1'b1;
          if (item_i.last) begin
            state_d = mse_pkg::ST_INIT; width_d = WW'(1); bank_d = 1'b0;
          end
        end
      end
      mse_pkg::ST_INIT: begin
        lo_d = '0; i_d = '0; k_d = '0;
        j_d = ((WW+1)'(width_q) > (WW+1)'(cnt_q)) ? (WW+1)'(cnt_q) : (WW+1)'(width_q);
        if ((WW+1)'(width_q) >= (WW+1)'(cnt_q)) begin
          state_d = mse_pkg::ST_EMIT;
        end else begin
          state_d = mse_pkg::ST_MERGE;
        end
      end
      mse_pkg::ST_MERGE: begin
        if (k_q < hi) begin
          k_d = k_q + (WW+1)'(1);
          if (pick_a) i_d = i_q + (WW+1)'(1);
          else j_d = j_q + (WW+1)'(1);
        end else if (hi >= (WW+1)'(cnt_q)) begin
          bank_d = ~bank_q; width_d = {width_q[WW-2:0], 1'b0};
          state_d = mse_pkg::ST_INIT;
        end else begin
          lo_d = hi; i_d = hi; k_d = hi;
          j_d = ((hi + (WW+1)'(width_q)) > (WW+1)'(cnt_q)) ? (WW+1)'(cnt_q)
              : hi + (WW+1)'(width_q);
        end
      end
      mse_pkg::ST_EMIT: begin
        if (emit_ld) begin
          out_v_d = 1'b1;
          k_d = k_q + (WW+1)'(1);
          if ((k_q + (WW+1)'(1)) == (WW+1)'(cnt_q)) begin
            state_d = mse_pkg::ST_LOAD; cnt_d = '0; ovf_d = 1'b0;
          end
        end
      end
      default: state_d = mse_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mse_pkg::ST_LOAD; cnt_q <= '0; ovf_q <= 1'b0; bank_q <= 1'b0;
      width_q <= '0; lo_q <= '0; i_q <= '0; j_q <= '0; k_q <= '0; out_v_q <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; ovf_q <= ovf_d; bank_q <= bank_d;
      width_q <= width_d; lo_q <= lo_d; i_q <= i_d; j_q <= j_d; k_q <= k_d;
      out_v_q <= out_v_d;
    end
  end

  assign empty_o     = !out_v_q;
  assign value_out_o = out_val_q;
  assign last_out_o  = out_last_q;
  assign overflow_o  = out_ovf_q;

  `MSE_NEVER(a_cnt_range, cnt_q > CW'(MaxItems))
  `MSE_NEVER(a_take_only_load, take_i && (state_q != mse_pkg::ST_LOAD))
  `MSE_ASSERT(a_merge_bound, (state_q == mse_pkg::ST_MERGE) |-> (k_q <= hi))
  `MSE_ASSERT(a_emit_nonempty, (state_q == mse_pkg::ST_EMIT) |-> (cnt_q != '0))
endmodule
